### hdl/cbv_pkg.sv
// cbv_pkg: shared constants, status codes, result type and the byte-wide crc-32 step
// for the config blob validator; no dependencies
package cbv_pkg;

    localparam int unsigned MAGIC_BYTES  = 8;
    localparam int unsigned HEADER_BYTES = 20;

    localparam int unsigned CFG_DATA_W  = 64;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned OUT_TDATA_W = 104;

    localparam logic [CFG_INDEX_W-1:0] CFG_MAGIC_WORD  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FMT_VERSION = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCHEMA      = 2'd2;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_TOO_SHORT   = 3'd1;
    localparam logic [2:0] ST_BAD_MAGIC   = 3'd2;
    localparam logic [2:0] ST_BAD_VERSION = 3'd3;
    localparam logic [2:0] ST_BAD_SCHEMA  = 3'd4;
    localparam logic [2:0] ST_LEN_MISMATCH = 3'd5;
    localparam logic [2:0] ST_BAD_CRC     = 3'd6;

    localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

    // packed so that status lands in the lowest bits
    typedef struct packed {
        logic [31:0] stored_crc;
        logic [31:0] payload_length;
        logic [15:0] schema_version_out;
        logic [15:0] fmt_version_out;
        logic [2:0]  status;
    } t_result;

    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'h0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

### hdl/cbv_out_buf.sv
// cbv_out_buf: two-entry result buffer (output register plus skid entry)
// depends on cbv_pkg for the result type
module cbv_out_buf
    import cbv_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_result,
    output logic    o_ready,
    output logic    o_valid,
    input  logic    i_pop_ready,
    output t_result o_result
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    w_pop;

    assign w_pop    = r_out_valid && i_pop_ready;
    assign o_ready  = !r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                if (w_pop) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end
            end else if (i_push) begin
                if (!r_out_valid || w_pop) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (w_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_pop) begin
                r_out <= r_skid;
            end
        end else if (i_push) begin
            if (!r_out_valid || w_pop) begin
                r_out <= i_result;
            end else begin
                r_skid <= i_result;
            end
        end
    end

    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid) else $error("skid entry held with empty output");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !r_skid_valid) else $error("result pushed into full buffer");

    a_skid_moves_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid && w_pop |=> r_out_valid && !r_skid_valid)
        else $error("skid entry not moved to output");

endmodule

### hdl/config_blob_validator_core.sv
// config_blob_validator_core: header capture, magic check, crc-32 and status for a byte stream
// depends on cbv_pkg and cbv_out_buf
// One byte beat is taken every clock cycle while s_axis_tready is high; all work for a byte
// (magic compare, header field capture, one byte-wide crc-32 xor network, length and crc
// compares) sits between the blob state registers and the result buffer. A blob's result
// goes to the output register, or to the skid entry while that register holds a stalled result.
// The output holds two results; s_axis_tready drops only when both are waiting, so bytes flow on.
module config_blob_validator_core
    import cbv_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,   // data_byte
    input  logic                   s_axis_tlast,   // last_byte
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // status[2:0], fmt_version_out[18:3], schema_version_out[34:19],
    // payload_length[66:35], stored_crc[98:67], zero fill[103:99]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic [63:0] r_magic_word;
    logic [15:0] r_exp_fmt_version;
    logic [15:0] r_exp_schema;

    logic [31:0] r_byte_index;
    logic        r_magic_good;
    logic [15:0] r_fmt_version;
    logic [15:0] r_schema_version;
    logic [31:0] r_payload_length;
    logic [31:0] r_header_crc;
    logic [31:0] r_running_crc;

    logic [31:0] n_byte_index;
    logic        n_magic_good;
    logic [15:0] n_fmt_version;
    logic [15:0] n_schema_version;
    logic [31:0] n_payload_length;
    logic [31:0] n_header_crc;
    logic [31:0] n_running_crc;

    logic        w_accept;
    logic        w_push;
    logic [2:0]  w_status;
    t_result     w_result;
    t_result     w_out_result;
    logic [31:0] w_idx;
    logic [7:0]  w_byte;

    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign w_push   = w_accept && s_axis_tlast;
    assign w_idx    = r_byte_index;
    assign w_byte   = s_axis_tdata;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic_word      <= 64'h0;
            r_exp_fmt_version <= 16'd1;
            r_exp_schema      <= 16'd0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_MAGIC_WORD:  r_magic_word      <= i_cfg_data;
                CFG_FMT_VERSION: r_exp_fmt_version <= i_cfg_data[15:0];
                CFG_SCHEMA:      r_exp_schema      <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // per-byte update
    always_comb begin
        n_magic_good     = r_magic_good;
        n_fmt_version    = r_fmt_version;
        n_schema_version = r_schema_version;
        n_payload_length = r_payload_length;
        n_header_crc     = r_header_crc;
        n_running_crc    = r_running_crc;
        if (w_idx < 32'(MAGIC_BYTES)) begin
            if (r_magic_word[{w_idx[2:0], 3'b000} +: 8] != w_byte) begin
                n_magic_good = 1'b0;
            end
        end else if (w_idx < 32'd10) begin
            n_fmt_version[{w_idx[0], 3'b000} +: 8] = w_byte;
        end else if (w_idx < 32'd12) begin
            n_schema_version[{w_idx[0], 3'b000} +: 8] = w_byte;
        end else if (w_idx < 32'd16) begin
            n_payload_length[{w_idx[1:0], 3'b000} +: 8] = w_byte;
        end else if (w_idx < 32'(HEADER_BYTES)) begin
            n_header_crc[{w_idx[1:0], 3'b000} +: 8] = w_byte;
        end else begin
            n_running_crc = crc32_byte(r_running_crc, w_byte);
        end
        n_byte_index = (w_idx == 32'hFFFF_FFFF) ? w_idx : w_idx + 32'd1;
    end

    always_comb begin
        if (n_byte_index < 32'(HEADER_BYTES)) begin
            w_status = ST_TOO_SHORT;
        end else if (!n_magic_good) begin
            w_status = ST_BAD_MAGIC;
        end else if (n_fmt_version != r_exp_fmt_version) begin
            w_status = ST_BAD_VERSION;
        end else if (n_schema_version != r_exp_schema) begin
            w_status = ST_BAD_SCHEMA;
        end else if (n_payload_length != n_byte_index - 32'(HEADER_BYTES)) begin
            w_status = ST_LEN_MISMATCH;
        end else if ((n_running_crc ^ CRC_ONES) != n_header_crc) begin
            w_status = ST_BAD_CRC;
        end else begin
            w_status = ST_OK;
        end
        w_result = '0;
        w_result.status = w_status;
        if (w_status == ST_OK) begin
            w_result.fmt_version_out    = n_fmt_version;
            w_result.schema_version_out = n_schema_version;
            w_result.payload_length     = n_payload_length;
            w_result.stored_crc         = n_header_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_push) begin
            r_byte_index     <= 32'h0;
            r_magic_good     <= 1'b1;
            r_fmt_version    <= 16'h0;
            r_schema_version <= 16'h0;
            r_payload_length <= 32'h0;
            r_header_crc     <= 32'h0;
            r_running_crc    <= CRC_ONES;
        end else if (w_accept) begin
            r_byte_index     <= n_byte_index;
            r_magic_good     <= n_magic_good;
            r_fmt_version    <= n_fmt_version;
            r_schema_version <= n_schema_version;
            r_payload_length <= n_payload_length;
            r_header_crc     <= n_header_crc;
            r_running_crc    <= n_running_crc;
        end
    end

    cbv_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_result    (w_result),
        .o_ready     (s_axis_tready),
        .o_valid     (m_axis_tvalid),
        .i_pop_ready (m_axis_tready),
        .o_result    (w_out_result)
    );

    assign m_axis_tdata = {(OUT_TDATA_W - $bits(t_result))'(0), w_out_result};

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |=> r_byte_index == 32'h0 && r_running_crc == CRC_ONES && r_magic_good)
        else $error("blob state not cleared after last beat");

    a_fields_zero_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[2:0] != ST_OK |-> m_axis_tdata[98:3] == '0)
        else $error("header fields leak on error status");

    a_count_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && !s_axis_tlast && r_byte_index != 32'hFFFF_FFFF
        |=> r_byte_index == $past(r_byte_index) + 32'd1)
        else $error("byte counter did not advance");

endmodule

### test/tb_blob_pkg.sv
// tb_blob_pkg: blob kinds for stimulus, a crc-32 byte update and the blob scoreboard class
// the scoreboard tracks its own copy of the validator state and configuration; depends on cbv_pkg
package tb_blob_pkg;
    import cbv_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

    typedef enum int {
        BLOB_OK,
        BLOB_SHORT,
        BLOB_MAGIC,
        BLOB_FMT_VER,
        BLOB_SCHEMA,
        BLOB_LENGTH,
        BLOB_CRC,
        BLOB_NOISE
    } t_blob_kind;

    // reflected crc-32, one data bit per step, lsb first
    function automatic logic [31:0] crc_update(logic [31:0] c, logic [7:0] d);
        logic [31:0] r;
        int i;
        r = c;
        for (i = 0; i < 8; i++) begin
            r = (r >> 1) ^ ((r[0] ^ d[i]) ? CRC_POLY : 32'h0);
        end
        return r;
    endfunction

    class blob_scoreboard;
        logic [63:0] magic;
        logic [15:0] want_version;
        logic [15:0] want_schema;

        logic [31:0] count;
        bit          magic_ok;
        logic [15:0] hdr_version;
        logic [15:0] hdr_schema;
        logic [31:0] hdr_length;
        logic [31:0] hdr_crc;
        logic [31:0] crc_reg;

        t_result pending[$];
        int      errors;

        function new();
            magic        = '0;
            want_version = 16'd1;
            want_schema  = '0;
            errors       = 0;
            clear_blob();
        endfunction

        function void clear_blob();
            count       = '0;
            magic_ok    = 1'b1;
            hdr_version = '0;
            hdr_schema  = '0;
            hdr_length  = '0;
            hdr_crc     = '0;
            crc_reg     = CRC_ONES;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
            case (index)
                CFG_MAGIC_WORD:  magic = value;
                CFG_FMT_VERSION: want_version = value[15:0];
                CFG_SCHEMA:      want_schema = value[15:0];
                default: ;
            endcase
        endfunction

        function void note_byte(logic [7:0] b, logic last);
            t_result r;
            int      pos;
            pos = int'(count);
            if (count < MAGIC_BYTES) begin
                if (magic[8*pos +: 8] != b) magic_ok = 1'b0;
            end else if (count < 10) begin
                hdr_version[8*(pos-8) +: 8] = b;
            end else if (count < 12) begin
                hdr_schema[8*(pos-10) +: 8] = b;
            end else if (count < 16) begin
                hdr_length[8*(pos-12) +: 8] = b;
            end else if (count < HEADER_BYTES) begin
                hdr_crc[8*(pos-16) +: 8] = b;
            end else begin
                crc_reg = crc_update(crc_reg, b);
            end
            count = (count == 32'hFFFF_FFFF) ? count : count + 32'd1;
            if (!last) return;

            r = '0;
            if (count < HEADER_BYTES)
                r.status = ST_TOO_SHORT;
            else if (!magic_ok)
                r.status = ST_BAD_MAGIC;
            else if (hdr_version != want_version)
                r.status = ST_BAD_VERSION;
            else if (hdr_schema != want_schema)
                r.status = ST_BAD_SCHEMA;
            else if (hdr_length != count - HEADER_BYTES)
                r.status = ST_LEN_MISMATCH;
            else if ((crc_reg ^ CRC_ONES) != hdr_crc)
                r.status = ST_BAD_CRC;
            else
                r.status = ST_OK;
            if (r.status == ST_OK) begin
                r.fmt_version_out    = hdr_version;
                r.schema_version_out = hdr_schema;
                r.payload_length     = hdr_length;
                r.stored_crc         = hdr_crc;
            end
            pending.push_back(r);
            clear_blob();
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s expected %0h got %0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] beat);
            t_result got;
            t_result want;
            got = beat[$bits(t_result)-1:0];
            if (pending.size() == 0) begin
                $error("result beat with no blob outstanding, status %0d", got.status);
                errors++;
                return;
            end
            want = pending.pop_front();
            check_field("status", want.status, got.status);
            check_field("fmt_version_out", want.fmt_version_out, got.fmt_version_out);
            check_field("schema_version_out", want.schema_version_out, got.schema_version_out);
            check_field("payload_length", want.payload_length, got.payload_length);
            check_field("stored_crc", want.stored_crc, got.stored_crc);
            check_field("zero fill", '0, beat[OUT_TDATA_W-1:$bits(t_result)]);
        endfunction
    endclass

endpackage

### test/tb_top.sv
// tb_top: drives blobs of every status through config_blob_validator_core with random
// gaps and output stalls, checks each result beat against the blob scoreboard
// depends on cbv_pkg, tb_blob_pkg and the validator rtl
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cbv_pkg::*;
    import tb_blob_pkg::*;

    localparam int unsigned ITEMS       = 850;
    localparam int unsigned CYCLE_LIMIT = 600000;

    typedef logic [7:0] t_byte_q[$];

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_wr_en;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata;   // data_byte
    logic                   s_axis_tlast;   // last_byte
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // status[2:0], fmt_version_out[18:3], schema_version_out[34:19],
    // payload_length[66:35], stored_crc[98:67], zero fill[103:99]
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    blob_scoreboard sb = new();
    bit             no_idle = 1'b0;
    int unsigned    bytes_sent = 0;
    int unsigned    blobs_sent = 0;
    int unsigned    cycles = 0;

    config_blob_validator_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) sb.note_byte(s_axis_tdata, s_axis_tlast);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    initial begin
        int gap;
        m_axis_tready <= 1'b0;
        @(posedge i_clk);
        forever begin
            gap = pick_gap();
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    function automatic t_byte_q build_blob(t_blob_kind kind, int plen);
        t_byte_q     q;
        t_byte_q     pay;
        logic [15:0] ver;
        logic [15:0] sch;
        logic [31:0] len;
        logic [31:0] crc;
        logic [31:0] flip;
        int          i;
        if (kind == BLOB_NOISE) begin
            for (i = 0; i < plen; i++) q.push_back(8'($urandom));
            return q;
        end
        ver  = sb.want_version;
        sch  = sb.want_schema;
        len  = (kind == BLOB_SHORT) ? 32'd0 : 32'(plen);
        crc  = CRC_ONES;
        flip = $urandom;
        if (flip == 0) flip = 32'd1;
        for (i = 0; i < int'(len); i++) begin
            pay.push_back(8'($urandom));
            crc = crc_update(crc, pay[i]);
        end
        crc = crc ^ CRC_ONES;
        case (kind)
            BLOB_FMT_VER: ver = ver ^ 16'($urandom_range(1, 65535));
            BLOB_SCHEMA:  sch = sch ^ 16'($urandom_range(1, 65535));
            BLOB_LENGTH:  len = len ^ flip;
            BLOB_CRC:     crc = crc ^ flip;
            default: ;
        endcase
        for (i = 0; i < 8; i++) q.push_back(sb.magic[8*i +: 8]);
        if (kind == BLOB_MAGIC) begin
            i = $urandom_range(0, 7);
            q[i] = q[i] ^ 8'($urandom_range(1, 255));
        end
        for (i = 0; i < 2; i++) q.push_back(ver[8*i +: 8]);
        for (i = 0; i < 2; i++) q.push_back(sch[8*i +: 8]);
        for (i = 0; i < 4; i++) q.push_back(len[8*i +: 8]);
        for (i = 0; i < 4; i++) q.push_back(crc[8*i +: 8]);
        q = {q, pay};
        if (kind == BLOB_SHORT) begin
            while (q.size() > plen) void'(q.pop_back());
        end
        return q;
    endfunction

    task automatic send_byte(logic [7:0] b, logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        bytes_sent++;
    endtask

    task automatic send_range(t_byte_q q, int lo, int hi);
        int i;
        for (i = lo; i < hi; i++) send_byte(q[i], i == q.size() - 1);
    endtask

    task automatic send_blob(t_blob_kind kind, int plen);
        t_byte_q q;
        q = build_blob(kind, plen);
        send_range(q, 0, q.size());
        blobs_sent++;
    endtask

    // stop input and let every outstanding result come out before a register write
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
        sb.write_reg(index, value);
    endtask

    // upper bits of the version registers carry junk that must be masked off
    task automatic write_config(logic [63:0] m, logic [15:0] v, logic [15:0] s);
        write_reg(CFG_MAGIC_WORD, m);
        write_reg(CFG_FMT_VERSION, {32'($urandom), 16'($urandom), v});
        write_reg(CFG_SCHEMA, {32'($urandom), 16'($urandom), s});
        write_reg(CFG_UNUSED, {32'($urandom), 32'($urandom)});
        i_cfg_wr_en <= 1'b0;
    endtask

    initial begin
        t_byte_q     q;
        logic [63:0] m2;
        t_blob_kind  kind;
        int          plen;
        int          r;
        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_index   <= CFG_MAGIC_WORD;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset configuration
        send_blob(BLOB_OK, 0);
        send_blob(BLOB_OK, 3);
        send_blob(BLOB_SHORT, 1);
        send_blob(BLOB_SHORT, 19);
        send_blob(BLOB_MAGIC, 2);
        send_blob(BLOB_FMT_VER, 2);
        send_blob(BLOB_SCHEMA, 2);
        send_blob(BLOB_LENGTH, 2);
        send_blob(BLOB_CRC, 2);
        drain();
        write_config('1, 16'hFFFF, 16'hFFFF);
        send_blob(BLOB_OK, 1);
        send_blob(BLOB_FMT_VER, 0);
        drain();
        write_config('0, 16'h0000, 16'h0000);
        send_blob(BLOB_OK, 0);

        // magic and versions rewritten halfway through the magic bytes
        q = build_blob(BLOB_OK, 4);
        send_range(q, 0, 4);
        drain();
        m2 = {32'($urandom), 32'($urandom)};
        write_config(m2, 16'($urandom), 16'($urandom));
        for (int i = 4; i < 8; i++) q[i] = m2[8*i +: 8];
        q[8]  = sb.want_version[7:0];
        q[9]  = sb.want_version[15:8];
        q[10] = sb.want_schema[7:0];
        q[11] = sb.want_schema[15:8];
        send_range(q, 4, q.size());
        blobs_sent++;

        while (bytes_sent < ITEMS) begin
            if (blobs_sent % 8 == 0) begin
                drain();
                r = $urandom_range(0, 5);
                if (r == 0)
                    write_config('1, 16'hFFFF, 16'hFFFF);
                else if (r == 1)
                    write_config('0, 16'h0000, 16'h0000);
                else
                    write_config({32'($urandom), 32'($urandom)}, 16'($urandom),
                                 16'($urandom));
                no_idle = ($urandom_range(0, 4) == 0);
            end
            r = $urandom_range(0, 99);
            if (r < 55)      kind = BLOB_OK;
            else if (r < 60) kind = BLOB_SHORT;
            else if (r < 66) kind = BLOB_MAGIC;
            else if (r < 72) kind = BLOB_FMT_VER;
            else if (r < 78) kind = BLOB_SCHEMA;
            else if (r < 84) kind = BLOB_LENGTH;
            else if (r < 92) kind = BLOB_CRC;
            else             kind = BLOB_NOISE;
            if (kind == BLOB_SHORT)
                plen = $urandom_range(1, HEADER_BYTES - 1);
            else if (kind == BLOB_NOISE)
                plen = $urandom_range(1, 60);
            else if ($urandom_range(0, 9) == 0)
                plen = $urandom_range(13, 200);
            else
                plen = $urandom_range(0, 12);
            send_blob(kind, plen);
        end

        drain();
        repeat (5) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### config_blob_validator_core.f
hdl/cbv_pkg.sv
hdl/cbv_out_buf.sv
hdl/config_blob_validator_core.sv
test/tb_blob_pkg.sv
test/tb_top.sv
